### hdl/sphere_wireframe_segment_generator_unit_defines.svh
// Assertion macros for the sphere wireframe segment generator.
// No dependencies; included by files that carry concurrent checks.
`ifndef SPHERE_WIREFRAME_SEGMENT_GENERATOR_UNIT_DEFINES_SVH
`define SPHERE_WIREFRAME_SEGMENT_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SWSG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define SWSG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hdl/swsg_pkg.sv
// Shared types, constants and the arctangent table of the segment generator.
// No dependencies; imported by swsg_cordic and the top level.
package swsg_pkg;

   localparam int ANGLE_BITS              = 16;
   localparam int COORD_BITS              = 12;
   localparam int TRIG_FRACTION_BITS_DEF  = 16;
   localparam int CSR_DATA_BITS           = 16;
   localparam int CSR_INDEX_BITS          = 3;
   localparam int RADIUS_BITS             = 10;
   localparam int SCALE_BITS              = 8;
   localparam int CORDIC_STEPS            = 28;
   localparam int CORDIC_GAIN             = 652032874;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROLL   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_YAW    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CX     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CY     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VSCALE = 3'd6;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] polar_angle;
      logic [ANGLE_BITS-1:0] azimuth_angle;
      logic                  new_polyline;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } rsp_type;

   function automatic logic [29:0] atan_f(input logic [4:0] idx);
      logic [29:0] r;
      unique case (idx)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

### hdl/swsg_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin.
// Depends on swsg_pkg for the angle width, gain and arctangent table.
module swsg_cordic #(
   parameter int TRIG_FRACTION_BITS = swsg_pkg::TRIG_FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [swsg_pkg::ANGLE_BITS-1:0]      angle,
   output logic                                 done,
   output logic signed [TRIG_FRACTION_BITS+1:0] cos_val,
   output logic signed [TRIG_FRACTION_BITS+1:0] sin_val
);
   import swsg_pkg::*;

   localparam int F  = TRIG_FRACTION_BITS;
   localparam int CW = 34;
   localparam int TW = F + 2;
   localparam int SH = 30 - F;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0]           step_ff, step_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [1:0]           quad_ff, quad_in;
   logic [31:0]          a32;
   logic signed [CW-1:0] xs, ys, at, half, one, xr, yr, xc, yc;
   logic signed [TW-1:0] cx, cy;

   always_comb begin
      a32     = 32'(angle) << (32 - ANGLE_BITS);
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      at      = CW'(atan_f(step_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      quad_in = quad_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CW'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = CW'(a32[29:0]);
         quad_in = a32[31:30];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      half = CW'(1) << (SH - 1);
      one  = CW'(1) << F;
      xr   = (x_ff + half) >>> SH;
      yr   = (y_ff + half) >>> SH;
      xc   = (xr > one) ? one : ((xr < -one) ? -one : xr);
      yc   = (yr > one) ? one : ((yr < -one) ? -one : yr);
      cx   = TW'(xc);
      cy   = TW'(yc);
      unique case (quad_ff)
         2'd0: begin cos_val = cx;  sin_val = cy;  end
         2'd1: begin cos_val = -cy; sin_val = cx;  end
         2'd2: begin cos_val = -cx; sin_val = -cy; end
         default: begin cos_val = cy; sin_val = -cx; end
      endcase
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      quad_ff <= quad_in;
   end

endmodule

### hdl/sphere_wireframe_segment_generator_unit.sv
// Per point: 2 CORDIC runs (28 steps each), then 14 multiply/writeback pairs and an
// emit state that waits for rsp_ready; a hidden point, or one drawn with the pen up,
// frees the unit with no response. One word at a time: the next accept waits for idle.
// After reset and after each angle write the rotation matrix is rebuilt (3 CORDIC runs
// plus 14 multiply pairs) while req_ready stays low.
// Reset: synchronous, active high; control and CSR registers only, not the datapath.
`include "sphere_wireframe_segment_generator_unit_defines.svh"
module sphere_wireframe_segment_generator_unit #(
   parameter int TRIG_FRACTION_BITS = swsg_pkg::TRIG_FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  swsg_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output swsg_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [swsg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [swsg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import swsg_pkg::*;

   localparam int F    = TRIG_FRACTION_BITS;
   localparam int TW   = F + 2;
   localparam int AW   = F + 14;
   localparam int BW   = F + 2;
   localparam int PW   = AW + BW;
   localparam int ACW  = PW + 2;
   localparam logic [3:0] STEP_LAST = 4'd13;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TRIG = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_WB   = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      mode_ff, mode_in;
   logic      build_req_ff, build_req_in;
   logic      start_ff, start_in;
   logic [1:0] tidx_ff, tidx_in;
   logic [3:0] step_ff, step_in;
   logic      pen_ff, pen_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [ANGLE_BITS-1:0]  roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [SCALE_BITS-1:0]  vs_ff, vs_in;

   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in, seg_ff, seg_in;
   logic signed [TW-1:0]  cc_ff [3];
   logic signed [TW-1:0]  cc_in [3];
   logic signed [TW-1:0]  ss_ff [3];
   logic signed [TW-1:0]  ss_in [3];
   logic signed [TW-1:0]  m_ff  [9];
   logic signed [TW-1:0]  m_in  [9];
   logic signed [AW-1:0]  f_ff  [3];
   logic signed [AW-1:0]  f_in  [3];
   logic signed [AW-1:0]  p0_ff, p0_in, u_ff, u_in, v_ff, v_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0]  prod_ff;
   logic signed [COORD_BITS-1:0] lx_ff, lx_in, ly_ff, ly_in, xq_ff, xq_in;

   logic                  cor_done;
   logic signed [TW-1:0]  cor_cos, cor_sin;
   logic [ANGLE_BITS-1:0] cor_angle;
   logic signed [AW-1:0]  mul_a;
   logic signed [BW-1:0]  mul_b;
   logic signed [ACW-1:0] pe, pr, sum, lim, cmax, cmin, cxe, cye, xw, yw;
   logic                  trig_last;

   function automatic logic signed [ACW-1:0] rnd_f(input logic signed [ACW-1:0] v,
                                                    input int k);
      logic signed [ACW-1:0] h;
      h = ACW'(1) << (k - 1);
      return (v + h) >>> k;
   endfunction

   function automatic logic signed [ACW-1:0] clamp_f(input logic signed [ACW-1:0] v,
                                                      input logic signed [ACW-1:0] lo,
                                                      input logic signed [ACW-1:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   swsg_cordic #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_val (cor_cos),
      .sin_val (cor_sin)
   );

   assign req_ready = (state_ff == ST_IDLE) && !build_req_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (mode_ff) begin
         unique case (tidx_ff)
            2'd0:    cor_angle = roll_ff;
            2'd1:    cor_angle = pitch_ff;
            default: cor_angle = yaw_ff;
         endcase
      end else begin
         cor_angle = (tidx_ff == 2'd0) ? req_ff.polar_angle : req_ff.azimuth_angle;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (mode_ff) begin
         unique case (step_ff)
            4'd0:  begin mul_a = AW'(cc_ff[1]); mul_b = cc_ff[2]; end
            4'd1:  begin mul_a = AW'(cc_ff[1]); mul_b = ss_ff[2]; end
            4'd2:  begin mul_a = AW'(ss_ff[0]); mul_b = cc_ff[1]; end
            4'd3:  begin mul_a = AW'(cc_ff[0]); mul_b = cc_ff[1]; end
            4'd4:  begin mul_a = AW'(ss_ff[0]); mul_b = ss_ff[1]; end
            4'd5:  begin mul_a = u_ff;          mul_b = cc_ff[2]; end
            4'd6:  begin mul_a = AW'(cc_ff[0]); mul_b = ss_ff[2]; end
            4'd7:  begin mul_a = u_ff;          mul_b = ss_ff[2]; end
            4'd8:  begin mul_a = AW'(cc_ff[0]); mul_b = cc_ff[2]; end
            4'd9:  begin mul_a = AW'(cc_ff[0]); mul_b = ss_ff[1]; end
            4'd10: begin mul_a = u_ff;          mul_b = cc_ff[2]; end
            4'd11: begin mul_a = AW'(ss_ff[0]); mul_b = ss_ff[2]; end
            4'd12: begin mul_a = u_ff;          mul_b = ss_ff[2]; end
            4'd13: begin mul_a = AW'(ss_ff[0]); mul_b = cc_ff[2]; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         unique case (step_ff)
            4'd0:  begin mul_a = AW'(ss_ff[0]); mul_b = BW'(radius_ff); end
            4'd1:  begin mul_a = p0_ff;         mul_b = cc_ff[1]; end
            4'd2:  begin mul_a = p0_ff;         mul_b = ss_ff[1]; end
            4'd3:  begin mul_a = AW'(cc_ff[0]); mul_b = BW'(radius_ff); end
            4'd4:  begin mul_a = f_ff[0];       mul_b = m_ff[2]; end
            4'd5:  begin mul_a = f_ff[1];       mul_b = m_ff[5]; end
            4'd6:  begin mul_a = f_ff[2];       mul_b = m_ff[8]; end
            4'd7:  begin mul_a = f_ff[0];       mul_b = m_ff[0]; end
            4'd8:  begin mul_a = f_ff[1];       mul_b = m_ff[3]; end
            4'd9:  begin mul_a = f_ff[2];       mul_b = m_ff[6]; end
            4'd10: begin mul_a = f_ff[0];       mul_b = m_ff[1]; end
            4'd11: begin mul_a = f_ff[1];       mul_b = m_ff[4]; end
            4'd12: begin mul_a = f_ff[2];       mul_b = m_ff[7]; end
            4'd13: begin mul_a = p0_ff;         mul_b = BW'(vs_ff); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      build_req_in = build_req_ff;
      start_in     = 1'b0;
      tidx_in      = tidx_ff;
      step_in      = step_ff;
      pen_in       = pen_ff;
      rsp_valid_in = rsp_valid_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      radius_in    = radius_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      vs_in        = vs_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      seg_in       = seg_ff;
      cc_in        = cc_ff;
      ss_in        = ss_ff;
      m_in         = m_ff;
      f_in         = f_ff;
      p0_in        = p0_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      xq_in        = xq_ff;

      pe   = ACW'(prod_ff);
      pr   = rnd_f(pe, F);
      sum  = acc_ff + pe;
      lim  = ACW'(1) << (F + 1);
      cmax = (ACW'(1) << (COORD_BITS - 1)) - ACW'(1);
      cmin = -cmax - ACW'(1);
      cxe  = ACW'(cx_ff);
      cye  = ACW'(cy_ff);
      xw   = clamp_f(rnd_f(sum, 2 * F) + cxe, cmin, cmax);
      yw   = clamp_f(rnd_f(pe, F + 8) + cye, cmin, cmax);
      trig_last = mode_ff ? (tidx_ff == 2'd2) : (tidx_ff == 2'd1);

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROLL:   begin roll_in  = csr_wdata[ANGLE_BITS-1:0]; build_req_in = 1'b1; end
            CSR_PITCH:  begin pitch_in = csr_wdata[ANGLE_BITS-1:0]; build_req_in = 1'b1; end
            CSR_YAW:    begin yaw_in   = csr_wdata[ANGLE_BITS-1:0]; build_req_in = 1'b1; end
            CSR_RADIUS: radius_in = csr_wdata[RADIUS_BITS-1:0];
            CSR_CX:     cx_in     = csr_wdata[RADIUS_BITS-1:0];
            CSR_CY:     cy_in     = csr_wdata[RADIUS_BITS-1:0];
            CSR_VSCALE: vs_in     = csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (build_req_ff) begin
               build_req_in = csr_we && (csr_index == CSR_ROLL || csr_index == CSR_PITCH
                                         || csr_index == CSR_YAW);
               mode_in  = 1'b1;
               tidx_in  = 2'd0;
               start_in = 1'b1;
               state_in = ST_TRIG;
            end else if (req_valid) begin
               req_in   = req_data;
               if (req_data.new_polyline) pen_in = 1'b0;
               mode_in  = 1'b0;
               tidx_in  = 2'd0;
               start_in = 1'b1;
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            if (cor_done) begin
               cc_in[tidx_ff] = cor_cos;
               ss_in[tidx_ff] = cor_sin;
               if (trig_last) begin
                  step_in  = '0;
                  state_in = ST_MUL;
               end else begin
                  tidx_in  = tidx_ff + 2'd1;
                  start_in = 1'b1;
               end
            end
         end
         ST_MUL: state_in = ST_WB;
         ST_WB: begin
            step_in  = step_ff + 4'd1;
            state_in = ST_MUL;
            if (mode_ff) begin
               unique case (step_ff)
                  4'd0: begin
                     m_in[0] = TW'(clamp_f(pr, -lim, lim - ACW'(1)));
                     m_in[2] = TW'(clamp_f(-ACW'(ss_ff[1]), -lim, lim - ACW'(1)));
                  end
                  4'd1:  m_in[1] = TW'(clamp_f(pr, -lim, lim - ACW'(1)));
                  4'd2:  m_in[5] = TW'(clamp_f(pr, -lim, lim - ACW'(1)));
                  4'd3:  m_in[8] = TW'(clamp_f(pr, -lim, lim - ACW'(1)));
                  4'd4, 4'd9: u_in = AW'(pr);
                  4'd5, 4'd7, 4'd10, 4'd12: v_in = AW'(pr);
                  4'd6:  m_in[3] = TW'(clamp_f(ACW'(v_ff) - pr, -lim, lim - ACW'(1)));
                  4'd8:  m_in[4] = TW'(clamp_f(ACW'(v_ff) + pr, -lim, lim - ACW'(1)));
                  4'd11: m_in[6] = TW'(clamp_f(ACW'(v_ff) + pr, -lim, lim - ACW'(1)));
                  4'd13: begin
                     m_in[7]  = TW'(clamp_f(ACW'(v_ff) - pr, -lim, lim - ACW'(1)));
                     state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end else begin
               unique case (step_ff)
                  4'd0: p0_in   = AW'(pe);
                  4'd1: f_in[0] = AW'(pr);
                  4'd2: f_in[1] = AW'(pr);
                  4'd3: f_in[2] = AW'(pe);
                  4'd4, 4'd7, 4'd10: acc_in = pe;
                  4'd5, 4'd8, 4'd11: acc_in = sum;
                  4'd6: begin
                     if (sum <= ACW'(0)) begin
                        pen_in   = 1'b0;
                        state_in = ST_IDLE;
                     end
                  end
                  4'd9:  xq_in = COORD_BITS'(xw);
                  4'd12: p0_in = AW'(rnd_f(sum, F));
                  4'd13: begin
                     seg_in.start_x = lx_ff;
                     seg_in.start_y = ly_ff;
                     seg_in.end_x   = xq_ff;
                     seg_in.end_y   = COORD_BITS'(yw);
                     lx_in          = xq_ff;
                     ly_in          = COORD_BITS'(yw);
                     pen_in         = 1'b1;
                     state_in       = pen_ff ? ST_EMIT : ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = seg_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b1;
         build_req_ff <= 1'b1;
         start_ff     <= 1'b0;
         tidx_ff      <= '0;
         step_ff      <= '0;
         pen_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         roll_ff      <= ANGLE_BITS'(0);
         pitch_ff     <= ANGLE_BITS'(5461);
         yaw_ff       <= ANGLE_BITS'(1820);
         radius_ff    <= RADIUS_BITS'(190);
         cx_ff        <= RADIUS_BITS'(300);
         cy_ff        <= RADIUS_BITS'(165);
         vs_ff        <= SCALE_BITS'(205);
         lx_ff        <= '0;
         ly_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         build_req_ff <= build_req_in;
         start_ff     <= start_in;
         tidx_ff      <= tidx_in;
         step_ff      <= step_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         radius_ff    <= radius_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         vs_ff        <= vs_in;
         lx_ff        <= lx_in;
         ly_ff        <= ly_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      seg_ff  <= seg_in;
      cc_ff   <= cc_in;
      ss_ff   <= ss_in;
      m_ff    <= m_in;
      f_ff    <= f_in;
      p0_ff   <= p0_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      xq_ff   <= xq_in;
      prod_ff <= PW'(mul_a * mul_b);
   end

   `SWSG_ASSERT_NEXT(a_accept_starts_trig, clock, reset, req_valid && req_ready,
                     state_ff == ST_TRIG && start_ff)
   `SWSG_ASSERT_NOW(a_done_only_in_trig, clock, reset, cor_done, state_ff == ST_TRIG)
   `SWSG_ASSERT_NOW(a_rebuild_blocks_req, clock, reset, build_req_ff, !req_ready)

endmodule
